// File: src/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// shared types, constants and the arctangent table for the compass heading
// pipeline
// ----------------------------------------------------------------------------
package chs_pkg;

  // angle accumulator in units of 1/256 centidegree
  localparam int ANG_W = 25;
  localparam int FRAC_BITS = 8;
  localparam int ANGLE_W = ANG_W - FRAC_BITS;
  localparam int SUM_W = ANGLE_W + 1;
  localparam int HEAD_W = 16;
  localparam int DECL_W = 16;

  // guard bits below the axis readings, and headroom for cordic gain
  localparam int GUARD_BITS = 20;
  localparam int GROWTH_BITS = 2;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 25'sd2304000;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 25'sd128;
  localparam logic signed [ANGLE_W-1:0] ANG_MAX = 17'sd18000;
  localparam logic signed [ANGLE_W-1:0] ANG_MIN = -17'sd17999;
  localparam logic signed [SUM_W-1:0] FULL_CIRCLE = 18'sd36000;
  localparam logic signed [DECL_W-1:0] DECL_MAX = 16'sd18000;
  localparam logic signed [DECL_W-1:0] DECL_MIN = -16'sd18000;
  localparam logic signed [DECL_W-1:0] DECL_RESET = -16'sd255;

  typedef struct packed {
    logic valid;
    logic zero;
  } cell_ctrl_t;

  // atan(2^-i) in units of 1/256 centidegree
  function automatic logic signed [ANG_W-1:0] arc_at(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:  a = 25'sd1152000;
      1:  a = 25'sd680065;
      2:  a = 25'sd359328;
      3:  a = 25'sd182400;
      4:  a = 25'sd91554;
      5:  a = 25'sd45822;
      6:  a = 25'sd22916;
      7:  a = 25'sd11459;
      8:  a = 25'sd5730;
      9:  a = 25'sd2865;
      10: a = 25'sd1432;
      11: a = 25'sd716;
      12: a = 25'sd358;
      13: a = 25'sd179;
      14: a = 25'sd90;
      15: a = 25'sd45;
      16: a = 25'sd22;
      17: a = 25'sd11;
      18: a = 25'sd6;
      19: a = 25'sd3;
      20: a = 25'sd1;
      21: a = 25'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: src/chs_entry.sv
// ----------------------------------------------------------------------------
// chs_entry
// entry cell: zero detect, quadrant pre-rotation and guard scaling
// ----------------------------------------------------------------------------
module chs_entry #(
  parameter int AXIS_WIDTH = 12,
  parameter int W = 35
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  input  logic signed [AXIS_WIDTH-1:0] x_axis,
  input  logic signed [AXIS_WIDTH-1:0] y_axis,
  output logic                         up_ready,
  output chs_pkg::cell_ctrl_t          ctrl,
  output logic signed [W-1:0]          x,
  output logic signed [W-1:0]          y,
  output logic signed [chs_pkg::ANG_W-1:0] z,
  input  logic                         down_ready
);

  logic adv;
  logic signed [W-1:0] xe, ye, xr, yr;
  logic signed [chs_pkg::ANG_W-1:0] zr;
  logic zero_next;

  assign adv = !ctrl.valid || down_ready;
  assign up_ready = adv;

  always_comb begin
    xe = W'(x_axis);
    ye = W'(y_axis);
    xr = xe;
    yr = ye;
    zr = '0;
    if (x_axis[AXIS_WIDTH-1]) begin
      if (!y_axis[AXIS_WIDTH-1]) begin
        xr = ye;
        yr = -xe;
        zr = chs_pkg::QUARTER_TURN;
      end else begin
        xr = -ye;
        yr = xe;
        zr = -chs_pkg::QUARTER_TURN;
      end
    end
    zero_next = (x_axis == '0) && (y_axis == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (adv) begin
      ctrl.valid <= up_valid;
      ctrl.zero <= zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x <= xr <<< chs_pkg::GUARD_BITS;
      y <= yr <<< chs_pkg::GUARD_BITS;
      z <= zr;
    end
  end

endmodule

// File: src/chs_cell.sv
// ----------------------------------------------------------------------------
// chs_cell
// one cordic vectoring micro-rotation, registered
// ----------------------------------------------------------------------------
module chs_cell #(
  parameter int W = 35,
  parameter int STAGE = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  chs_pkg::cell_ctrl_t              up_ctrl,
  input  logic signed [W-1:0]              up_x,
  input  logic signed [W-1:0]              up_y,
  input  logic signed [chs_pkg::ANG_W-1:0] up_z,
  output logic                             up_ready,
  output chs_pkg::cell_ctrl_t              ctrl,
  output logic signed [W-1:0]              x,
  output logic signed [W-1:0]              y,
  output logic signed [chs_pkg::ANG_W-1:0] z,
  input  logic                             down_ready
);

  localparam logic signed [chs_pkg::ANG_W-1:0] ARC = chs_pkg::arc_at(STAGE);

  logic adv;
  logic signed [W-1:0] xs, ys, x_next, y_next;
  logic signed [chs_pkg::ANG_W-1:0] z_next;

  assign adv = !ctrl.valid || down_ready;
  assign up_ready = adv;

  always_comb begin
    xs = up_x >>> STAGE;
    ys = up_y >>> STAGE;
    if (!up_y[W-1]) begin
      x_next = up_x + ys;
      y_next = up_y - xs;
      z_next = up_z + ARC;
    end else begin
      x_next = up_x - ys;
      y_next = up_y + xs;
      z_next = up_z - ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (adv) begin
      ctrl <= up_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// File: src/chs_finish.sv
// ----------------------------------------------------------------------------
// chs_finish
// rounding and clamp of the angle, then declination add and wrap into the
// output register
// ----------------------------------------------------------------------------
module chs_finish (
  input  logic                                clk,
  input  logic                                rst,
  input  chs_pkg::cell_ctrl_t                 up_ctrl,
  input  logic signed [chs_pkg::ANG_W-1:0]    up_z,
  input  logic signed [chs_pkg::DECL_W-1:0]   decl,
  output logic                                up_ready,
  output logic                                out_valid,
  output logic [chs_pkg::HEAD_W-1:0]          heading,
  input  logic                                out_stall
);

  logic a_valid, a_adv, b_adv;
  logic signed [chs_pkg::ANGLE_W-1:0] ang, ang_next;
  logic signed [chs_pkg::ANG_W-1:0] zp;
  logic signed [chs_pkg::SUM_W-1:0] sum, h_next;

  assign b_adv = !out_valid || !out_stall;
  assign a_adv = !a_valid || b_adv;
  assign up_ready = a_adv;

  // round to nearest centidegree, ties upward, then clamp; zero vectors give zero
  always_comb begin
    zp = up_z + chs_pkg::ROUND_HALF;
    ang_next = zp[chs_pkg::ANG_W-1:chs_pkg::FRAC_BITS];
    if (ang_next > chs_pkg::ANG_MAX) begin
      ang_next = chs_pkg::ANG_MAX;
    end else if (ang_next < chs_pkg::ANG_MIN) begin
      ang_next = chs_pkg::ANG_MIN;
    end
    if (up_ctrl.zero) begin
      ang_next = '0;
    end
  end

  always_comb begin
    sum = chs_pkg::SUM_W'(ang) + chs_pkg::SUM_W'(decl);
    h_next = sum;
    if (sum < 0) begin
      h_next = sum + chs_pkg::FULL_CIRCLE;
    end else if (sum > chs_pkg::FULL_CIRCLE) begin
      h_next = sum - chs_pkg::FULL_CIRCLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= up_ctrl.valid;
      end
      if (b_adv) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      ang <= ang_next;
    end
    if (b_adv) begin
      heading <= h_next[chs_pkg::HEAD_W-1:0];
    end
  end

endmodule

// File: src/compass_heading_from_axes_top.sv
// ----------------------------------------------------------------------------
// compass_heading_from_axes_top
// compass heading in centidegrees from two magnetometer axes, by a pipelined
// cordic vectoring chain, plus a declination offset with wrap to 0..36000
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              beat
// input     in         in_valid / in_stall    x_axis, y_axis
// output    out        out_valid / out_stall  heading
// config    in         cfg_valid / cfg_ready  declination_offset
//
// one sample accepted per cycle while in_stall is low; stages are the entry cell,
// one cell per micro-rotation, rounding stage, output register
// every cell holds its beat only while the cell after it is full and stalled,
// so bubbles collapse and a waiting result does not block new samples
// rst is synchronous: clears all valid flags and loads declination -255
// cfg_ready is always high; the write is clamped to -18000..18000
// ----------------------------------------------------------------------------
module compass_heading_from_axes_top #(
  parameter int AXIS_WIDTH = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [AXIS_WIDTH-1:0]       x_axis,
  input  logic signed [AXIS_WIDTH-1:0]       y_axis,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [chs_pkg::HEAD_W-1:0]         heading,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic signed [chs_pkg::DECL_W-1:0]  declination_offset
);

  // axis magnitude, sign, cordic growth and guard bits
  localparam int W = AXIS_WIDTH + 1 + chs_pkg::GROWTH_BITS + chs_pkg::GUARD_BITS;

  // clamped declination register
  logic signed [chs_pkg::DECL_W-1:0] decl;

  // per-stage beats; index k is the output of stage k (0 = entry cell)
  chs_pkg::cell_ctrl_t ctrl_s [CORDIC_STAGES+1];
  logic signed [W-1:0] x_s [CORDIC_STAGES+1];
  logic signed [W-1:0] y_s [CORDIC_STAGES+1];
  logic signed [chs_pkg::ANG_W-1:0] z_s [CORDIC_STAGES+1];
  logic ready_s [CORDIC_STAGES+1];
  logic entry_ready;

  assign cfg_ready = 1'b1;
  assign in_stall = !entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= chs_pkg::DECL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (declination_offset > chs_pkg::DECL_MAX) begin
        decl <= chs_pkg::DECL_MAX;
      end else if (declination_offset < chs_pkg::DECL_MIN) begin
        decl <= chs_pkg::DECL_MIN;
      end else begin
        decl <= declination_offset;
      end
    end
  end

  // pre-rotation into the right half plane
  chs_entry #(
    .AXIS_WIDTH(AXIS_WIDTH),
    .W(W)
  ) u_entry (
    .clk(clk),
    .rst(rst),
    .up_valid(in_valid),
    .x_axis(x_axis),
    .y_axis(y_axis),
    .up_ready(entry_ready),
    .ctrl(ctrl_s[0]),
    .x(x_s[0]),
    .y(y_s[0]),
    .z(z_s[0]),
    .down_ready(ready_s[0])
  );

  // chain of micro-rotation cells, one shift distance each
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chs_cell #(
      .W(W),
      .STAGE(g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .up_ctrl(ctrl_s[g]),
      .up_x(x_s[g]),
      .up_y(y_s[g]),
      .up_z(z_s[g]),
      .up_ready(ready_s[g]),
      .ctrl(ctrl_s[g+1]),
      .x(x_s[g+1]),
      .y(y_s[g+1]),
      .z(z_s[g+1]),
      .down_ready(ready_s[g+1])
    );
  end

  // rounding, declination and wrap; the x and y residues of the last cell
  // carry no further information
  chs_finish u_finish (
    .clk(clk),
    .rst(rst),
    .up_ctrl(ctrl_s[CORDIC_STAGES]),
    .up_z(z_s[CORDIC_STAGES]),
    .decl(decl),
    .up_ready(ready_s[CORDIC_STAGES]),
    .out_valid(out_valid),
    .heading(heading),
    .out_stall(out_stall)
  );

`ifndef SYNTHESIS
  localparam int DEPTH = CORDIC_STAGES + 3;
  localparam int CNT_W = $clog2(DEPTH + 1);
  logic [CNT_W-1:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_valid && !in_stall)
                             - CNT_W'(out_valid && !out_stall);
    end
  end

  // never more beats in flight than the pipeline has cells
  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(DEPTH))
    else $error("beats in flight exceed pipeline depth");

  // a full pipeline with a stalled output must push back on the input
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_flight == CNT_W'(DEPTH)) && out_stall |-> in_stall)
    else $error("full pipeline accepted a new beat");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading <= chs_pkg::HEAD_W'(36000)))
    else $error("heading outside 0..36000");
`endif

endmodule

// File: sim/compass_heading_from_axes_top_tb.sv
// ----------------------------------------------------------------------------
// compass_heading_from_axes_top_tb
// self-checking bench for the cordic compass heading pipeline: a short table
// of corner samples, then random phases under several declinations, each
// heading checked against a typed-in value or a bit-true cordic predictor kept in
// the bench
module compass_heading_from_axes_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXIS_W = 12;
  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 3;
  localparam int ARC_LEN = 24;

  // run shape
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_PHASE = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_PRINTS = 30;

  // fixed point of the angle path
  localparam longint QUARTER_ANGLE = 64'sd2304000;
  localparam longint GUARD_GAIN = 64'sd1048576;
  localparam longint HALF_TURN = 64'sd18000;
  localparam longint TURN = 64'sd36000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [AXIS_W-1:0]          x_axis = '0;
  logic signed [AXIS_W-1:0]          y_axis = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [chs_pkg::HEAD_W-1:0]        heading;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic signed [chs_pkg::DECL_W-1:0] declination_offset = '0;

  // atan(2^-i) in 1/256 centidegree
  longint arc_units [0:ARC_LEN-1] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45,
    22, 11, 6, 3, 1, 1, 0, 0
  };

  // headings still owed by the block, oldest first
  logic [chs_pkg::HEAD_W-1:0] pending_headings [$];

  // bench copy of the declination register, as written (clamped on use)
  logic signed [chs_pkg::DECL_W-1:0] decl_copy = -16'sd255;

  int error_count = 0;
  int samples_sent = 0;
  int headings_checked = 0;
  int decl_writes = 0;
  int burst_left = 0;

  // long output hold-off: main asks, receiver process serves
  int hold_asks = 0;
  int hold_served = 0;

  // directed sample table; want is typed in only where it is plain
  typedef struct packed {
    bit set_decl;
    int decl;
    int x;
    int y;
    bit known;
    int want;
  } directed_row_t;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{1'b0, 0, 0, 0, 1'b1, 35745},            // both axes zero, reset declination
    '{1'b0, 0, 2047, 0, 1'b0, 0},
    '{1'b0, 0, -2048, 0, 1'b0, 0},            // negative x on the axis: half turn
    '{1'b0, 0, -1, 0, 1'b0, 0},
    '{1'b0, 0, 0, 2047, 1'b0, 0},
    '{1'b0, 0, 0, -2048, 1'b0, 0},
    '{1'b0, 0, 2047, 2047, 1'b0, 0},
    '{1'b0, 0, -2048, -2048, 1'b0, 0},
    '{1'b0, 0, -2048, 2047, 1'b0, 0},
    '{1'b0, 0, 2047, -2048, 1'b0, 0},
    '{1'b0, 0, 1, 0, 1'b0, 0},
    '{1'b0, 0, 0, 1, 1'b0, 0},
    '{1'b0, 0, 0, -1, 1'b0, 0},
    '{1'b0, 0, -1, -1, 1'b0, 0},
    '{1'b0, 0, -2048, -1, 1'b0, 0},           // just short of minus half turn
    '{1'b0, 0, -2048, 1, 1'b0, 0},            // just short of plus half turn
    '{1'b1, 0, 0, 0, 1'b1, 0},
    '{1'b0, 0, -2048, 0, 1'b0, 0},
    '{1'b1, 18000, 0, 0, 1'b1, 18000},
    '{1'b0, 0, -1, 0, 1'b0, 0},               // sum lands on a full turn
    '{1'b1, -18000, 0, 0, 1'b1, 18000},       // negative sum wraps up
    '{1'b0, 0, -2048, -1, 1'b0, 0},
    '{1'b1, 32767, 0, 0, 1'b1, 18000},        // declination above range saturates
    '{1'b1, -32768, 0, 0, 1'b1, 18000},       // and below range too
    '{1'b1, -255, 0, 0, 1'b1, 35745}
  };

  compass_heading_from_axes_top #(
    .AXIS_WIDTH(AXIS_W),
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .x_axis(x_axis),
    .y_axis(y_axis),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .heading(heading),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .declination_offset(declination_offset)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // heading of one sample: quadrant pre-rotation, cordic vectoring, rounding,
  // angle saturation, declination clamp and wrap into 0..36000
  function automatic logic [chs_pkg::HEAD_W-1:0] predict_heading(
    input logic signed [AXIS_W-1:0] xa,
    input logic signed [AXIS_W-1:0] ya,
    input logic signed [chs_pkg::DECL_W-1:0] decl
  );
    longint x, y, z, t, xs, ys, d, h;
    int i;
    x = xa;
    y = ya;
    z = 0;
    // both axes zero: angle taken as zero
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = QUARTER_ANGLE;
        end else begin
          x = -y;
          y = t;
          z = -QUARTER_ANGLE;
        end
      end
      x = x * GUARD_GAIN;
      y = y * GUARD_GAIN;
      for (i = 0; i < STAGES && i < ARC_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arc_units[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arc_units[i];
        end
      end
      // nearest centidegree, ties upward, then keep within half a turn
      z = (z + 64'sd128) >>> 8;
      if (z > HALF_TURN) z = HALF_TURN;
      if (z < -HALF_TURN + 1) z = -HALF_TURN + 1;
    end
    d = decl;
    if (d > HALF_TURN) d = HALF_TURN;
    if (d < -HALF_TURN) d = -HALF_TURN;
    h = z + d;
    if (h < 0) h = h + TURN;
    if (h > TURN) h = h - TURN;
    return h[chs_pkg::HEAD_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [chs_pkg::HEAD_W-1:0] got,
                                 input logic [chs_pkg::HEAD_W-1:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic int corner_axis();
    case ($urandom_range(0, 5))
      0: return -2048;
      1: return -2047;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 2047;
    endcase
  endfunction

  // random sample: half the time anywhere on the plane, the rest near the axes,
  // near the negative x axis, tiny vectors or corners
  task automatic pick_axes(output logic signed [AXIS_W-1:0] xv,
                           output logic signed [AXIS_W-1:0] yv);
    int kind, a, b;
    kind = $urandom_range(0, 9);
    a = $urandom_range(0, 4095);
    b = $urandom_range(0, 4095);
    a = a - 2048;
    b = b - 2048;
    case (kind)
      5: begin
        a = $urandom_range(0, 31);
        b = $urandom_range(0, 31);
        a = a - 16;
        b = b - 16;
      end
      6: begin
        if ($urandom_range(0, 1) == 1) b = 0;
        else a = 0;
      end
      7: begin
        a = $urandom_range(1, 2048);
        a = -a;
        b = $urandom_range(0, 2);
        b = b - 1;
      end
      8: begin
        a = corner_axis();
        b = corner_axis();
      end
      9: begin
        if ($urandom_range(0, 1) == 1) a = corner_axis();
        else b = corner_axis();
      end
      default: ;
    endcase
    xv = a[AXIS_W-1:0];
    yv = b[AXIS_W-1:0];
  endtask

  // offer one sample and hold it until taken; then burst/gap pacing
  task automatic offer_sample(input logic signed [AXIS_W-1:0] xv,
                              input logic signed [AXIS_W-1:0] yv,
                              input bit known, input logic [chs_pkg::HEAD_W-1:0] want);
    int gap;
    in_valid <= 1'b1;
    x_axis <= xv;
    y_axis <= yv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (known) pending_headings.push_back(want);
    else pending_headings.push_back(predict_heading(xv, yv, decl_copy));
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short gaps, now and then a longer one
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 48);
    end
  endtask

  // register write with the pipe drained: every owed heading has come out
  task automatic set_declination(input int value);
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    declination_offset <= value[chs_pkg::DECL_W-1:0];
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    decl_copy = value[chs_pkg::DECL_W-1:0];
    decl_writes++;
  endtask

  // output side: compare every heading beat with the oldest owed value
  always @(posedge clk) begin : check_heading
    logic [chs_pkg::HEAD_W-1:0] want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_headings.size() == 0) begin
        report_mismatch("heading beat with none owed", heading, 'x);
      end else begin
        want = pending_headings.pop_front();
        if (heading !== want) report_mismatch("heading", heading, want);
        headings_checked++;
      end
    end
  end

  // receiver pacing: stretches of no stall, random stall, a periodic pattern,
  // and the long hold-off when main asks for it
  initial begin : receiver_pacing
    int mode, span, k, hold_count;
    @(posedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_served++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ((k % 3) == 2);
          default: out_stall <= ($urandom_range(0, 1) == 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog: too long without any beat on any channel ends the run
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1 ||
          cfg_valid)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: %0d cycles without a beat, %0d headings still owed",
             IDLE_LIMIT, pending_headings.size());
    $display("compass_heading_from_axes_top_tb: done, errors");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    directed_row_t row;
    logic signed [AXIS_W-1:0] xv, yv;
    int r, p, n, d;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, starting from the reset declination
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.set_decl) set_declination(row.decl);
      offer_sample(row.x[AXIS_W-1:0], row.y[AXIS_W-1:0], row.known,
                   row.want[chs_pkg::HEAD_W-1:0]);
    end

    // random phases, one declination each; the write itself drains the pipe
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: d = 18000;
        1: d = -18000;
        2: d = 0;
        4, 5: begin
          // whole 16-bit range, out-of-range values included
          d = $urandom_range(0, 65535);
          d = d - 32768;
        end
        6: d = 1;
        3, 7: begin
          d = $urandom_range(0, 36000);
          d = d - 18000;
        end
        default: d = -255;
      endcase
      set_declination(d);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while samples keep coming: pipe fills up
        if (p == HOLD_PHASE && n == 40) hold_asks++;
        pick_axes(xv, yv);
        offer_sample(xv, yv, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    // a little longer, to catch any stray beat
    repeat (2 * LATENCY) @(posedge clk);

    $display("run: %0d samples (%0d from the table), %0d headings checked",
             samples_sent, DIRECTED_ROWS, headings_checked);
    $display("run: %0d declination writes incl. both limits and out-of-range, one hold-off",
             decl_writes);
    if (error_count == 0) begin
      $display("compass_heading_from_axes_top_tb: done, clean");
    end else begin
      $display("compass_heading_from_axes_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/chs_pkg.sv
src/chs_entry.sv
src/chs_cell.sv
src/chs_finish.sv
src/compass_heading_from_axes_top.sv
sim/compass_heading_from_axes_top_tb.sv
